FILE: sv/tdht_pkg.sv
`timescale 1ns / 1ps
// Package of the term dictionary hash table.
// Holds the word types of both channels, the status codes and the hash constants.
package tdht_pkg;

    localparam int unsigned TableSlotsDef   = 1024;
    localparam int unsigned MaxTermBytesDef = 64;
    localparam int unsigned PostingDepthDef = 4096;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_POSTED    = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_INVALID   = 3'd4,
        ST_TABLE_FULL = 3'd5,
        ST_POST_FULL = 3'd6
    } t_status;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  term_byte;
        logic        term_last;
        logic [31:0] node_id;
        logic [15:0] frequency;
        logic [6:0]  word_position;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot;
        logic [12:0] posting_count;
        logic [31:0] fnv_hash;
        logic [10:0] distinct_terms;
    } t_out_word;

endpackage

FILE: sv/tdht_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result words.
// Depends on tdht_pkg for the word types.
interface tdht_in_if;
    logic                valid;
    logic                ready;
    tdht_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tdht_out_if;
    logic                valid;
    logic                ready;
    tdht_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/term_dictionary_hash_table_top.sv
`timescale 1ns / 1ps
// Term dictionary: a linear-probing hash table of terms hashed with FNV-1a, plus a
// posting store. Term bytes are accepted while a term is being collected. After the
// last byte the term is checked, the hash is reduced modulo the slot count by a
// reciprocal multiplication and one correcting subtraction, then each probed slot is
// read from the slot memory port and checked, the key bytes are read and compared one
// by one when length and hash match, the outcome is settled, the key of a new term is
// copied byte by byte into the key memory, and the result register is loaded, which
// waits while the previous result is still held. After reset the block runs a
// clearing pass over every slot of the slot memory, during which no word is accepted.
// Depends on tdht_pkg and tdht_if.
module term_dictionary_hash_table_top #(
    parameter int unsigned TABLE_SLOTS    = tdht_pkg::TableSlotsDef,
    parameter int unsigned MAX_TERM_BYTES = tdht_pkg::MaxTermBytesDef,
    parameter int unsigned POSTING_DEPTH  = tdht_pkg::PostingDepthDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tdht_in_if.sink    i_in,
    tdht_out_if.source o_out
);
    import tdht_pkg::*;

    localparam int unsigned SW = $clog2(TABLE_SLOTS);
    localparam int unsigned BW = $clog2(MAX_TERM_BYTES);
    localparam int unsigned LW = $clog2(MAX_TERM_BYTES + 1);
    localparam int unsigned PW = $clog2(POSTING_DEPTH);
    localparam int unsigned PCW = $clog2(POSTING_DEPTH + 1);
    localparam int unsigned OW = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned KEY_DEPTH = TABLE_SLOTS * (1 << BW);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

    typedef struct packed {
        logic           used;
        logic [LW-1:0]  len;
        logic [31:0]    hash;
        logic [PCW-1:0] total;
    } t_meta;

    typedef enum logic [11:0] {
        S_CLEAR     = 12'b000000000001,
        S_COLLECT   = 12'b000000000010,
        S_DECIDE    = 12'b000000000100,
        S_MOD       = 12'b000000001000,
        S_PROBE_RD  = 12'b000000010000,
        S_PROBE_CHK = 12'b000000100000,
        S_CMP_RD    = 12'b000001000000,
        S_CMP_CHK   = 12'b000010000000,
        S_SETTLE    = 12'b000100000000,
        S_COPY_RD   = 12'b001000000000,
        S_COPY_WR   = 12'b010000000000,
        S_RESULT    = 12'b100000000000
    } t_state;

    t_state r_state;

    t_meta  meta_mem [0:TABLE_SLOTS-1];
    logic [7:0] key_mem [0:KEY_DEPTH-1];
    logic [7:0] inc_mem [0:MAX_TERM_BYTES-1];
    logic [54:0] post_mem [0:POSTING_DEPTH-1];

    t_meta      meta_q;
    logic [7:0] key_q;
    logic [7:0] inc_q;

    logic           meta_we;
    t_meta          meta_wd;
    logic           post_we;

    logic [LW-1:0]  r_len;
    logic [31:0]    r_hash;
    logic           r_mode;
    logic [31:0]    r_node;
    logic [15:0]    r_freq;
    logic [6:0]     r_pos;
    logic [63:0]    r_prod;
    logic [32:0]    r_rem;
    logic [1:0]     r_k;
    logic [SW-1:0]  r_slot;
    logic [SW:0]    r_probe;
    logic [BW-1:0]  r_j;
    logic           r_found;
    logic           r_empty;
    logic [PCW-1:0] r_total;
    logic [PCW-1:0] r_fill;
    logic [OW-1:0]  r_occ;
    logic [2:0]     r_status;
    logic [SW-1:0]  r_res_slot;
    logic [PCW-1:0] r_res_count;
    logic [31:0]    r_res_hash;
    logic           r_out_valid;
    t_out_word      r_out;

    logic        accept;
    logic [7:0]  in_byte;
    logic        keep;
    logic        buf_we;
    logic [31:0] n_hash;
    logic [LW-1:0] n_len;
    logic [32:0] n_rem;
    logic        probe_last;
    logic [SW-1:0] slot_next;

    assign i_in.ready  = (r_state == S_COLLECT);
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        in_byte = i_in.data.term_byte;
        if (i_in.data.mode == MODE_LOOKUP && in_byte >= 8'h41 && in_byte <= 8'h5a) begin
            in_byte = in_byte + 8'h20;
        end
        keep = (in_byte != 8'h00) &&
               (i_in.data.mode == MODE_INSERT || 32'(r_len) < MAX_TERM_BYTES - 1);
        buf_we = accept && keep && (32'(r_len) < MAX_TERM_BYTES - 1);
        n_hash = r_hash;
        n_len  = r_len;
        if (keep) begin
            n_hash = 32'((r_hash ^ {24'h0, in_byte}) * FNV_PRIME);
            if (32'(r_len) < MAX_TERM_BYTES) begin
                n_len = r_len + LW'(1);
            end
        end
    end

    always_comb begin
        n_rem = (r_rem >= 33'(TABLE_SLOTS)) ? (r_rem - 33'(TABLE_SLOTS)) : r_rem;
        probe_last = (r_probe == (SW+1)'(TABLE_SLOTS - 1));
        slot_next  = (32'(r_slot) == TABLE_SLOTS - 1) ? '0 : (r_slot + SW'(1));
    end

    always_comb begin
        meta_we = 1'b0;
        meta_wd = '0;
        post_we = 1'b0;
        case (r_state)
            S_CLEAR: begin
                meta_we = 1'b1;
            end
            S_SETTLE: begin
                if (r_mode == MODE_INSERT && (r_found || r_empty) &&
                    32'(r_fill) < POSTING_DEPTH) begin
                    meta_we       = 1'b1;
                    post_we       = 1'b1;
                    meta_wd.used  = 1'b1;
                    meta_wd.len   = r_len;
                    meta_wd.hash  = r_hash;
                    meta_wd.total = r_found ? (r_total + PCW'(1)) : PCW'(1);
                end
            end
            default: begin
                meta_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[r_slot] <= meta_wd;
        end
        meta_q <= meta_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COPY_WR) begin
            key_mem[{r_slot, r_j}] <= inc_q;
        end
        key_q <= key_mem[{r_slot, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            inc_mem[r_len[BW-1:0]] <= in_byte;
        end
        inc_q <= inc_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (post_we) begin
            post_mem[r_fill[PW-1:0]] <= {r_node, r_freq, r_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_len       <= '0;
            r_hash      <= FNV_BASIS;
            r_fill      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_slot <= slot_next;
                    if (32'(r_slot) == TABLE_SLOTS - 1) begin
                        r_state <= S_COLLECT;
                    end
                end
                S_COLLECT: begin
                    if (accept) begin
                        r_len  <= n_len;
                        r_hash <= n_hash;
                        if (i_in.data.term_last) begin
                            r_mode  <= i_in.data.mode;
                            r_node  <= i_in.data.node_id;
                            r_freq  <= i_in.data.frequency;
                            r_pos   <= i_in.data.word_position;
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_res_slot  <= '0;
                    r_res_count <= '0;
                    r_res_hash  <= (r_len == '0) ? 32'h0 : r_hash;
                    r_k         <= 2'd0;
                    r_found     <= 1'b0;
                    r_empty     <= 1'b0;
                    r_probe     <= '0;
                    if (r_mode == MODE_INSERT &&
                        (r_len == '0 || 32'(r_len) >= MAX_TERM_BYTES || r_node == 32'h0)) begin
                        r_status <= ST_INVALID;
                        r_state  <= S_RESULT;
                    end else if (r_len == '0) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_RESULT;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_k <= r_k + 2'd1;
                    case (r_k)
                        2'd0: begin
                            r_prod <= 64'(r_hash) * 64'(RECIP);
                        end
                        2'd1: begin
                            r_rem <= {1'b0, r_hash} -
                                     33'(r_prod[63:32]) * 33'(TABLE_SLOTS);
                        end
                        default: begin
                            r_slot  <= n_rem[SW-1:0];
                            r_state <= S_PROBE_RD;
                        end
                    endcase
                end
                S_PROBE_RD: begin
                    r_state <= S_PROBE_CHK;
                end
                S_PROBE_CHK: begin
                    r_total <= meta_q.total;
                    r_j     <= '0;
                    if (!meta_q.used) begin
                        r_empty <= 1'b1;
                        r_state <= S_SETTLE;
                    end else if (meta_q.len == r_len && meta_q.hash == r_hash) begin
                        r_state <= S_CMP_RD;
                    end else if (probe_last) begin
                        r_state <= S_SETTLE;
                    end else begin
                        r_probe <= r_probe + (SW+1)'(1);
                        r_slot  <= slot_next;
                        r_state <= S_PROBE_RD;
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_CMP_CHK;
                end
                S_CMP_CHK: begin
                    if (key_q != inc_q) begin
                        if (probe_last) begin
                            r_state <= S_SETTLE;
                        end else begin
                            r_probe <= r_probe + (SW+1)'(1);
                            r_slot  <= slot_next;
                            r_state <= S_PROBE_RD;
                        end
                    end else if (r_j == BW'(r_len - LW'(1))) begin
                        r_found <= 1'b1;
                        r_state <= S_SETTLE;
                    end else begin
                        r_j     <= r_j + BW'(1);
                        r_state <= S_CMP_RD;
                    end
                end
                S_SETTLE: begin
                    r_state <= S_RESULT;
                    r_j     <= '0;
                    if (r_mode == MODE_LOOKUP) begin
                        if (r_found) begin
                            r_status    <= ST_FOUND;
                            r_res_slot  <= r_slot;
                            r_res_count <= r_total;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end else if (!r_found && !r_empty) begin
                        r_status <= ST_TABLE_FULL;
                    end else if (32'(r_fill) >= POSTING_DEPTH) begin
                        r_status    <= ST_POST_FULL;
                        r_res_slot  <= r_slot;
                        r_res_count <= r_found ? r_total : '0;
                    end else begin
                        r_fill     <= r_fill + PCW'(1);
                        r_res_slot <= r_slot;
                        if (r_found) begin
                            r_status    <= ST_POSTED;
                            r_res_count <= r_total + PCW'(1);
                        end else begin
                            r_status    <= ST_ADDED;
                            r_res_count <= PCW'(1);
                            r_occ       <= r_occ + OW'(1);
                            r_state     <= S_COPY_RD;
                        end
                    end
                end
                S_COPY_RD: begin
                    r_state <= S_COPY_WR;
                end
                S_COPY_WR: begin
                    if (r_j == BW'(r_len - LW'(1))) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_j     <= r_j + BW'(1);
                        r_state <= S_COPY_RD;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out.status         <= r_status;
                        r_out.slot           <= 10'(r_res_slot);
                        r_out.posting_count  <= (32'(r_res_count) > 32'h1fff) ?
                                                13'h1fff : 13'(r_res_count);
                        r_out.fnv_hash       <= r_res_hash;
                        r_out.distinct_terms <= (32'(r_occ) > 32'h7ff) ?
                                                11'h7ff : 11'(r_occ);
                        r_out_valid <= 1'b1;
                        r_len       <= '0;
                        r_hash      <= FNV_BASIS;
                        r_state     <= S_COLLECT;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the term dictionary hash table, with directed, random and fill phases.
// Results are predicted from a behavioral copy of the table and compared in order.
// Depends on tdht_pkg, tdht_if and term_dictionary_hash_table_top.
module testbench;
    import tdht_pkg::*;

    localparam int unsigned SLOTS = 1024;
    localparam int unsigned KEYMAX = 64;
    localparam int unsigned PDEPTH = 4096;
    localparam int unsigned STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tdht_in_if in_ch ();
    tdht_out_if out_ch ();

    term_dictionary_hash_table_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 clk = ~clk;

    t_in_word pending_words[$];
    t_out_word expected_results[$];

    bit         tbl_used[SLOTS];
    logic [7:0] tbl_key[SLOTS][KEYMAX];
    int         tbl_len[SLOTS];
    int         tbl_postings[SLOTS];
    int         postings_fill;
    int         terms_held;
    logic [7:0] term_buf[KEYMAX];
    int         acc_len;
    logic [31:0] acc_hash;

    int  mismatches = 0;
    int  words_sent = 0;
    int  quiet_from = 1 << 30;
    int  stall_cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_off = 0;
    bit  hold_done = 1'b0;
    int  results_seen = 0;

    function automatic void predict_result(t_in_word w);
        logic [7:0] b;
        logic [31:0] h;
        int s, i, start, status, oslot, ocount;
        bit found, empty, same;
        b = w.term_byte;
        found = 1'b0;
        empty = 1'b0;
        status = ST_INVALID;
        oslot = 0;
        ocount = 0;
        s = 0;
        if (b != 8'd0) begin
            if (w.mode == MODE_LOOKUP && b >= "A" && b <= "Z") b = b + 8'd32;
            if (w.mode == MODE_INSERT || acc_len < KEYMAX - 1) begin
                if (acc_len < KEYMAX - 1) term_buf[acc_len] = b;
                acc_hash = (acc_hash ^ {24'd0, b}) * FNV_PRIME;
                if (acc_len < KEYMAX) acc_len++;
            end
        end
        if (!w.term_last) return;
        h = (acc_len == 0) ? 32'd0 : acc_hash;
        if (w.mode == MODE_INSERT && (acc_len == 0 || acc_len >= KEYMAX || w.node_id == 0)) begin
            status = ST_INVALID;
        end else if (w.mode == MODE_LOOKUP && acc_len == 0) begin
            status = ST_NOT_FOUND;
        end else begin
            start = h % SLOTS;
            for (i = 0; i < SLOTS; i++) begin
                s = (start + i) % SLOTS;
                if (!tbl_used[s]) begin
                    empty = 1'b1;
                    break;
                end
                same = (tbl_len[s] == acc_len);
                for (int k = 0; k < acc_len && same; k++)
                    if (tbl_key[s][k] != term_buf[k]) same = 1'b0;
                if (same) begin
                    found = 1'b1;
                    break;
                end
            end
            if (w.mode == MODE_LOOKUP) begin
                if (found) begin
                    status = ST_FOUND;
                    oslot = s;
                    ocount = tbl_postings[s];
                end else begin
                    status = ST_NOT_FOUND;
                end
            end else if (!found && !empty) begin
                status = ST_TABLE_FULL;
            end else if (postings_fill >= PDEPTH) begin
                status = ST_POST_FULL;
                oslot = s;
                ocount = found ? tbl_postings[s] : 0;
            end else begin
                if (empty) begin
                    tbl_used[s] = 1'b1;
                    for (int k = 0; k < acc_len; k++) tbl_key[s][k] = term_buf[k];
                    tbl_len[s] = acc_len;
                    tbl_postings[s] = 0;
                    terms_held++;
                    status = ST_ADDED;
                end else begin
                    status = ST_POSTED;
                end
                postings_fill++;
                tbl_postings[s]++;
                oslot = s;
                ocount = tbl_postings[s];
            end
        end
        expected_results.push_back('{status: 3'(status), slot: 10'(oslot),
            posting_count: (ocount > 8191) ? 13'h1fff : 13'(ocount), fnv_hash: h,
            distinct_terms: (terms_held > 2047) ? 11'h7ff : 11'(terms_held)});
        acc_len = 0;
        acc_hash = FNV_BASIS;
    endfunction

    function automatic void push_word(logic m, logic [7:0] b, logic last, logic [31:0] node);
        pending_words.push_back('{mode: m, term_byte: b, term_last: last, node_id: node,
            frequency: 16'($urandom), word_position: 7'($urandom)});
    endfunction

    function automatic void push_term(logic m, byte unsigned chars[$], logic [31:0] node);
        foreach (chars[k]) push_word(m, chars[k], k == chars.size() - 1, node);
    endfunction

    function automatic void push_repeat(logic m, logic [7:0] b, int n, logic [31:0] node);
        for (int k = 0; k < n; k++) push_word(m, b, k == n - 1, node);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            acc_len = 0;
            acc_hash = FNV_BASIS;
            postings_fill = 0;
            terms_held = 0;
            foreach (tbl_used[k]) tbl_used[k] = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_result(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() != 0 && words_sent < quiet_from
                             && $urandom_range(0, 24) == 0) begin
                    send_gap = $urandom_range(0, 16);
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_words.pop_front();
                    words_sent++;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result word %p", out_ch.data);
                end else begin
                    t_out_word e;
                    e = expected_results.pop_front();
                    if (out_ch.data.status !== e.status || out_ch.data.slot !== e.slot
                        || out_ch.data.posting_count !== e.posting_count
                        || out_ch.data.fnv_hash !== e.fnv_hash
                        || out_ch.data.distinct_terms !== e.distinct_terms) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, got %p", e, out_ch.data);
                    end
                end
            end
            if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                hold_off = 400;
                out_ch.ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else if (words_sent < quiet_from && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT + 1100) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        byte unsigned word_list[48][$];
        byte unsigned chars[$];
        int n, pick;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;

        push_term(MODE_INSERT, '{"a", "p", "p", "l", "e"}, 32'd1);
        push_term(MODE_INSERT, '{"a", "p", "p", "l", "e"}, 32'hffffffff);
        push_term(MODE_LOOKUP, '{"A", "P", "P", "L", "E"}, 32'd0);
        push_term(MODE_LOOKUP, '{"p", "e", "a", "r"}, 32'd5);
        push_word(MODE_INSERT, 8'd0, 1'b1, 32'd7);
        push_word(MODE_LOOKUP, 8'd0, 1'b1, 32'd7);
        push_term(MODE_INSERT, '{"x"}, 32'd0);
        push_term(MODE_INSERT, '{"a", 8'd0, "b"}, 32'd9);
        push_term(MODE_LOOKUP, '{"A", "B", 8'd0}, 32'd9);
        push_term(MODE_INSERT, '{8'hff, 8'h80, 8'h01}, 32'h80000000);
        push_term(MODE_LOOKUP, '{8'hff, 8'h80, 8'h01}, 32'd3);
        push_repeat(MODE_INSERT, "z", 64, 32'd4);
        push_repeat(MODE_INSERT, "z", 70, 32'd4);
        push_repeat(MODE_INSERT, "z", 63, 32'd4);
        push_repeat(MODE_LOOKUP, "Z", 70, 32'd4);
        push_repeat(MODE_LOOKUP, "z", 62, 32'd4);
        push_word(MODE_INSERT, "Q", 1'b0, 32'd6);
        push_word(MODE_LOOKUP, "Q", 1'b1, 32'd6);
        push_term(MODE_LOOKUP, '{"q", "q"}, 32'd6);
        push_term(MODE_INSERT, '{8'hf5}, 32'h55aa55aa);

        foreach (word_list[k]) begin
            n = $urandom_range(1, 8);
            for (int j = 0; j < n; j++) word_list[k].push_back(8'($urandom_range(97, 122)));
        end
        while (pending_words.size() < 1320) begin
            pick = $urandom_range(0, 99);
            chars = {};
            if (pick < 80) begin
                chars = word_list[$urandom_range(0, 47)];
                foreach (chars[k]) if ($urandom_range(0, 4) == 0) chars[k] = chars[k] - 8'd32;
                push_term($urandom_range(0, 2) == 0 ? MODE_INSERT : MODE_LOOKUP, chars,
                          $urandom_range(0, 30) == 0 ? 32'd0 : $urandom);
            end else if (pick < 94) begin
                n = $urandom_range(1, 5);
                for (int j = 0; j < n; j++)
                    push_word(1'($urandom), 8'($urandom), j == n - 1, $urandom);
            end else begin
                push_repeat(1'($urandom), 8'($urandom_range(97, 122)),
                            $urandom_range(60, 70), $urandom);
            end
        end

        quiet_from = pending_words.size();
        for (int k = 0; k < 100; k++)
            push_term(MODE_INSERT, '{8'(8'hc0 + (k >> 5)), 8'(8'ha0 + (k & 31))}, $urandom | 1);
        push_term(MODE_LOOKUP, '{"n", "o", "n", "e"}, 32'd1);
        for (int k = 0; k < 10; k++) push_term(MODE_INSERT, '{8'hf5}, $urandom | 1);
        push_term(MODE_INSERT, '{8'hc0, 8'ha0}, 32'd2);
        push_term(MODE_LOOKUP, '{8'hf5}, 32'd2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
